@@ hw/rtl/iecho_pkg.sv @@
// shared types, constants and checksum helpers for the icmp echo responder
// no dependencies; imported by every module of the block
package iecho_pkg;

    // largest request that still gets a reply
    localparam logic [15:0] MAX_MESSAGE = 16'd1480;
    // position of the last header byte; a message ending before it is truncated
    localparam logic [15:0] HDR_LAST_POS = 16'd7;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // icmp type codes
    localparam logic [7:0] TYPE_ECHO_REPLY   = 8'd0;
    localparam logic [7:0] TYPE_ECHO_REQUEST = 8'd8;

    // header byte positions
    localparam logic [15:0] POS_TYPE   = 16'd0;
    localparam logic [15:0] POS_CKS_HI = 16'd2;
    localparam logic [15:0] POS_CKS_LO = 16'd3;
    localparam logic [15:0] POS_ID_HI  = 16'd4;
    localparam logic [15:0] POS_ID_LO  = 16'd5;
    localparam logic [15:0] POS_SEQ_HI = 16'd6;
    localparam logic [15:0] POS_SEQ_LO = 16'd7;

    // type word delta for 8 -> 0 in ones' complement
    localparam logic [15:0] TYPE_DELTA = 16'hF7FF;

    // event slots; the first six double as verdict codes
    typedef enum logic [2:0] {
        EV_SENT    = 3'd0,
        EV_TRUNC   = 3'd1,
        EV_BADSUM  = 3'd2,
        EV_BCAST   = 3'd3,
        EV_RXREPLY = 3'd4,
        EV_UNKNOWN = 3'd5,
        EV_REQRX   = 3'd6
    } iecho_event_t;

    localparam int NUM_EVENTS = 7;

    // one queue entry: the held byte result and, on the last byte, the final result
    typedef struct packed {
        logic         has_held;
        logic [7:0]   held_byte;
        logic         is_last;
        logic [7:0]   final_byte;
        iecho_event_t verdict;
        logic [31:0]  address;
        logic [15:0]  length;
        logic [15:0]  ident;
        logic [15:0]  sequence_num;
        logic [31:0]  count;
    } iecho_entry_t;

    // queue status toward front and back
    typedef struct packed {
        logic full;
        logic empty;
    } iecho_qstat_t;

    // 16-bit ones' complement add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // byte as it leaves in the reply
    function automatic logic [7:0] iecho_rewrite(
        input logic [7:0]  mtype,
        input logic [15:0] pos,
        input logic [15:0] cks,
        input logic [7:0]  b
    );
        logic [15:0] nc;
        nc = ~oc_add(~cks, TYPE_DELTA);
        if (mtype != TYPE_ECHO_REQUEST)
            return b;
        else if (pos == POS_TYPE)
            return TYPE_ECHO_REPLY;
        else if (pos == POS_CKS_HI)
            return nc[15:8];
        else if (pos == POS_CKS_LO)
            return nc[7:0];
        else
            return b;
    endfunction

endpackage

@@ hw/rtl/iecho_front.sv @@
// front part: accepts message bytes, tracks the header and checksum, issues verdicts
// depends on iecho_pkg; feeds entries into iecho_queue
module iecho_front import iecho_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_fire,
    input  logic [7:0]   data_byte,
    input  logic         last_byte,
    input  logic [31:0]  source_address,
    input  logic         is_broadcast,
    output logic         push,
    output iecho_entry_t push_entry
);

    logic [15:0] pos_reg, pos_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  pend_reg, pend_next;
    logic        odd_reg, odd_next;
    logic [7:0]  held_reg, held_next;
    logic [7:0]  type_reg, type_next;
    logic [15:0] cks_reg, cks_next;
    logic [15:0] ident_reg, ident_next;
    logic [15:0] seq_reg, seq_next;
    logic [15:0] lr_ident_reg, lr_ident_next;
    logic [15:0] lr_seq_reg, lr_seq_next;
    logic [31:0] cnt_reg [NUM_EVENTS];
    logic [31:0] cnt_next [NUM_EVENTS];

    logic [15:0]  word;
    logic [15:0]  total;
    logic         short_msg;
    logic         bad_sum;
    logic         req_rx;
    iecho_event_t verdict;
    logic [31:0]  cnt_sel;
    logic [31:0]  cnt_new;
    logic [31:0]  req_new;
    logic         fin;

    // header capture for this byte
    always_comb
    begin
        type_next  = type_reg;
        cks_next   = cks_reg;
        ident_next = ident_reg;
        seq_next   = seq_reg;
        case (pos_reg)
            POS_TYPE:   type_next  = data_byte;
            POS_CKS_HI: cks_next   = {data_byte, 8'd0};
            POS_CKS_LO: cks_next   = {cks_reg[15:8], data_byte};
            POS_ID_HI:  ident_next = {data_byte, 8'd0};
            POS_ID_LO:  ident_next = {ident_reg[15:8], data_byte};
            POS_SEQ_HI: seq_next   = {data_byte, 8'd0};
            POS_SEQ_LO: seq_next   = {seq_reg[15:8], data_byte};
            default:    ;
        endcase
    end

    // running sum; a lone final byte is padded with a zero low byte
    assign word  = odd_reg ? {pend_reg, data_byte} : {data_byte, 8'd0};
    assign total = oc_add(sum_reg, word);

    // verdict in priority order
    always_comb
    begin
        short_msg = pos_reg < HDR_LAST_POS;
        bad_sum   = total != 16'hFFFF;
        req_rx    = 1'b0;
        if (short_msg)
            verdict = EV_TRUNC;
        else if (bad_sum)
            verdict = EV_BADSUM;
        else if (type_next == TYPE_ECHO_REQUEST)
        begin
            if (is_broadcast)
                verdict = EV_BCAST;
            else
            begin
                req_rx  = 1'b1;
                verdict = (pos_reg >= MAX_MESSAGE) ? EV_TRUNC : EV_SENT;
            end
        end
        else if (type_next == TYPE_ECHO_REPLY)
            verdict = EV_RXREPLY;
        else
            verdict = EV_UNKNOWN;
    end

    // saturating counter bumps
    assign cnt_sel = cnt_reg[verdict];
    assign cnt_new = (cnt_sel == 32'hFFFF_FFFF) ? cnt_sel : cnt_sel + 32'd1;
    assign req_new = (cnt_reg[EV_REQRX] == 32'hFFFF_FFFF) ? cnt_reg[EV_REQRX]
                                                          : cnt_reg[EV_REQRX] + 32'd1;
    assign fin = in_fire && last_byte;

    always_comb
    begin
        for (int i = 0; i < NUM_EVENTS; i++)
        begin
            cnt_next[i] = cnt_reg[i];
            if (fin && (i == int'(verdict)))
                cnt_next[i] = cnt_new;
            if (fin && req_rx && (i == int'(EV_REQRX)))
                cnt_next[i] = req_new;
        end
    end

    // last echo reply seen
    always_comb
    begin
        lr_ident_next = lr_ident_reg;
        lr_seq_next   = lr_seq_reg;
        if (fin && verdict == EV_RXREPLY)
        begin
            lr_ident_next = ident_next;
            lr_seq_next   = seq_next;
        end
    end

    // per-message state, cleared after the last byte
    always_comb
    begin
        pos_next  = pos_reg;
        sum_next  = sum_reg;
        pend_next = pend_reg;
        odd_next  = odd_reg;
        held_next = held_reg;
        if (in_fire)
        begin
            if (last_byte)
            begin
                pos_next  = '0;
                sum_next  = '0;
                pend_next = '0;
                odd_next  = 1'b0;
                held_next = '0;
            end
            else
            begin
                if (pos_reg != 16'hFFFF)
                    pos_next = pos_reg + 16'd1;
                held_next = data_byte;
                odd_next  = ~odd_reg;
                if (odd_reg)
                    sum_next = total;
                else
                    pend_next = data_byte;
            end
        end
    end

    // entry toward the queue
    always_comb
    begin
        push = in_fire && (pos_reg != 16'd0 || last_byte);
        push_entry.has_held     = pos_reg != 16'd0;
        push_entry.held_byte    = iecho_rewrite(type_next, pos_reg - 16'd1, cks_next, held_reg);
        push_entry.is_last      = last_byte;
        push_entry.final_byte   = iecho_rewrite(type_next, pos_reg, cks_next, data_byte);
        push_entry.verdict      = verdict;
        push_entry.address      = source_address;
        push_entry.length       = (pos_reg == 16'hFFFF) ? pos_reg : pos_reg + 16'd1;
        push_entry.ident        = lr_ident_next;
        push_entry.sequence_num = lr_seq_next;
        push_entry.count        = cnt_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            sum_reg      <= '0;
            pend_reg     <= '0;
            odd_reg      <= 1'b0;
            held_reg     <= '0;
            type_reg     <= '0;
            cks_reg      <= '0;
            ident_reg    <= '0;
            seq_reg      <= '0;
            lr_ident_reg <= '0;
            lr_seq_reg   <= '0;
            for (int i = 0; i < NUM_EVENTS; i++)
                cnt_reg[i] <= '0;
        end
        else
        begin
            pos_reg      <= pos_next;
            sum_reg      <= sum_next;
            pend_reg     <= pend_next;
            odd_reg      <= odd_next;
            held_reg     <= held_next;
            lr_ident_reg <= lr_ident_next;
            lr_seq_reg   <= lr_seq_next;
            for (int i = 0; i < NUM_EVENTS; i++)
                cnt_reg[i] <= cnt_next[i];
            if (fin)
            begin
                type_reg  <= '0;
                cks_reg   <= '0;
                ident_reg <= '0;
                seq_reg   <= '0;
            end
            else if (in_fire)
            begin
                type_reg  <= type_next;
                cks_reg   <= cks_next;
                ident_reg <= ident_next;
                seq_reg   <= seq_next;
            end
        end
    end

    // a finished message leaves no per-message state behind
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        fin |=> (pos_reg == 16'd0 && !odd_reg && type_reg == 8'd0))
        else $error("message state not cleared after last byte");

endmodule

@@ hw/rtl/iecho_queue.sv @@
// short entry queue between the front and back parts
// depends on iecho_pkg
module iecho_queue import iecho_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  iecho_entry_t push_entry,
    input  logic         pop,
    output iecho_entry_t head,
    output iecho_qstat_t stat
);

    iecho_entry_t        mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign head       = mem_reg[rd_ptr_reg];
    assign stat.full  = count_reg == QCNT_W'(QDEPTH);
    assign stat.empty = count_reg == '0;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && stat.full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && stat.empty))
        else $error("pop from empty queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count out of range");

endmodule

@@ hw/rtl/iecho_back.sv @@
// back part: expands queue entries into output transfers through an output register
// depends on iecho_pkg; reads entries from iecho_queue
module iecho_back import iecho_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  iecho_entry_t  head,
    input  iecho_qstat_t  stat,
    output logic          pop,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [119:0]  m_axis_tdata,  // out_byte, reply_address, message_length,
                                         // recorded_ident, recorded_sequence, event_count
    output logic          m_axis_tlast,  // out_last
    output logic [2:0]    m_axis_tuser   // verdict
);

    logic          valid_reg, valid_next;
    logic          held_done_reg, held_done_next;
    logic [119:0]  data_reg, data_next;
    logic          last_reg, last_next;
    logic [2:0]    user_reg, user_next;
    logic          load;
    logic          emit_held;

    assign load      = !stat.empty && (!valid_reg || m_axis_tready);
    assign emit_held = head.has_held && !held_done_reg;
    assign pop       = load && (!emit_held || !head.is_last);

    // next transfer from the head entry
    always_comb
    begin
        valid_next     = valid_reg && !m_axis_tready;
        held_done_next = held_done_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        user_next      = user_reg;
        if (load)
        begin
            valid_next     = 1'b1;
            held_done_next = emit_held && head.is_last;
            if (emit_held)
            begin
                data_next = {112'd0, head.held_byte};
                last_next = 1'b0;
                user_next = '0;
            end
            else
            begin
                data_next = {head.count, head.sequence_num, head.ident,
                             head.length, head.address, head.final_byte};
                last_next = 1'b1;
                user_next = head.verdict;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            held_done_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            held_done_reg <= held_done_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        last_reg <= last_next;
        user_reg <= user_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tlast  = last_reg;
    assign m_axis_tuser  = user_reg;

endmodule

@@ hw/rtl/icmp_echo_responder_core.sv @@
// top level of the icmp echo responder
// depends on iecho_pkg, iecho_front, iecho_queue and iecho_back
//
// Bytes of an ICMP message enter on the slave stream, one per transfer, with
// the sender address and broadcast flag; each byte leaves one transfer later
// on the master stream, with echo requests rewritten in flight to replies
// (type and checksum). The transfer carrying the final byte has tlast set and
// carries the verdict, length, recorded reply fields and updated event count.
// The input takes one byte per cycle while the queue is not full. The first
// byte of a message produces no output transfer and the final byte produces
// two, so the output side keeps pace with the input; the four-entry queue
// between the classifying front end and the output stage absorbs the
// two-transfer entry and output stalls.
module icmp_echo_responder_core import iecho_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [39:0]   s_axis_tdata,  // data_byte, source_address
    input  logic          s_axis_tlast,  // last_byte
    input  logic [0:0]    s_axis_tuser,  // is_broadcast
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [119:0]  m_axis_tdata,  // out_byte, reply_address, message_length,
                                         // recorded_ident, recorded_sequence, event_count
    output logic          m_axis_tlast,  // out_last
    output logic [2:0]    m_axis_tuser   // verdict
);

    iecho_entry_t push_entry;
    iecho_entry_t head;
    iecho_qstat_t stat;
    logic         push;
    logic         pop;
    logic         in_fire;

    assign s_axis_tready = !stat.full;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // classify and rewrite
    iecho_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_fire        (in_fire),
        .data_byte      (s_axis_tdata[7:0]),
        .last_byte      (s_axis_tlast),
        .source_address (s_axis_tdata[39:8]),
        .is_broadcast   (s_axis_tuser[0]),
        .push           (push),
        .push_entry     (push_entry)
    );

    // decoupling queue
    iecho_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .stat       (stat)
    );

    // output stage
    iecho_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .stat          (stat),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
